FILE: src/pidl_pkg.sv
// Package for the positional insert/delete list: operation codes, status codes,
// cell control types and controller states. No dependencies.
package pidl_pkg;

    // Operation carried in the request tuser field.
    typedef enum logic [2:0] {
        MODE_CLEAR  = 3'd0,
        MODE_APPEND = 3'd1,
        MODE_INSERT = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    // Result status carried in the result tuser field.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int unsigned MODE_W     = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned POSITION_W = 8;
    localparam int unsigned LENGTH_W   = 8;

    // What every cell does this cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     rd_en;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_GROUP,
        S_RD_OUT
    } t_state;

endpackage

FILE: src/pidl_cell.sv
// One list cell: holds one word, shifts with its neighbors on insert/delete,
// and drives its word onto the read tree when selected. Uses pidl_pkg.
module pidl_cell #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned IDX_W      = 7,
    parameter int unsigned IDX        = 0
) (
    input  logic                  i_clk,
    input  pidl_pkg::t_cell_ctl   i_ctl,
    input  logic [IDX_W-1:0]      i_idx,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,   // word of cell IDX-1
    input  logic [DATA_WIDTH-1:0] i_right,  // word of cell IDX+1
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd_word
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [DATA_WIDTH-1:0] r_rd_word;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            pidl_pkg::CELL_INSERT: begin
                if (MY_IDX == i_idx) begin
                    n_data = i_value;
                end else if (MY_IDX > i_idx) begin
                    n_data = i_left;
                end
            end
            pidl_pkg::CELL_DELETE: begin
                if (MY_IDX >= i_idx) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data    <= n_data;
        r_rd_word <= (i_ctl.rd_en && (MY_IDX == i_idx)) ? r_data : '0;
    end

    assign o_data    = r_data;
    assign o_rd_word = r_rd_word;

endmodule

FILE: src/pidl_group.sv
// First level of the read tree: registered OR over one group of cell read words.
// No package dependencies.
module pidl_group #(
    parameter int unsigned DATA_WIDTH = 32,
    parameter int unsigned N          = 16
) (
    input  logic                          i_clk,
    input  logic [N-1:0][DATA_WIDTH-1:0]  i_words,
    output logic [DATA_WIDTH-1:0]         o_word
);

    logic [DATA_WIDTH-1:0] w_or;
    logic [DATA_WIDTH-1:0] r_word;

    // at most one cell of the list drives a nonzero word
    always_comb begin
        w_or = '0;
        for (int i = 0; i < N; i++) begin
            w_or = w_or | i_words[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= w_or;
    end

    assign o_word = r_word;

endmodule

FILE: src/positional_insert_delete_list.sv
// Positional insert/delete list: top level. Uses pidl_pkg, pidl_cell, pidl_group.
// Controller, length counter, cell chain, read tree and result register.
//
// Ordered list of up to CAPACITY words held in a row of cells, one word per
// cell; each request is one operation (tuser: 0 clear, 1 append, 2 insert,
// 3 delete, 4 read, others ignored with status ok). Insert and delete move
// every later cell by one place at once, each cell loading from its
// neighbor, so clear, append, insert, delete, ignored codes and any rejected
// request (out of range or list full) reach the result register in the next
// cycle. On a valid read the selected cell registers its word, a registered
// OR over groups of at most 16 cells follows, and the final OR across the
// groups lands in the result register. One request is in flight at a time;
// a new request is taken in the same cycle the pending result is taken.
// Positions are 1-based: insert accepts 1..length+1, delete and read accept
// 1..length. Every result carries the length after the operation. The
// list contents need no reset; only state, length and result valid are.
module positional_insert_delete_list #(
    parameter int unsigned CAPACITY   = 128,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // request channel
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: position [7:0], value [DATA_WIDTH+7:8], zero pad above
    input  logic [((pidl_pkg::POSITION_W+DATA_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // tuser: mode [2:0]
    input  logic [pidl_pkg::MODE_W-1:0]          i_s_tuser,

    // result channel
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata: read_value [DATA_WIDTH-1:0], length [DATA_WIDTH+7:DATA_WIDTH], zero pad
    output logic [((pidl_pkg::LENGTH_W+DATA_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // tuser: status [1:0]
    output logic [pidl_pkg::STATUS_W-1:0]        o_m_tuser
);

    localparam int unsigned IDX_W    = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W    = ((CNT_W > pidl_pkg::POSITION_W) ?
                                        CNT_W : pidl_pkg::POSITION_W) + 1;
    localparam int unsigned GRP      = (CAPACITY < 16) ? CAPACITY : 16;
    localparam int unsigned NGROUP   = (CAPACITY + GRP - 1) / GRP;
    localparam int unsigned OUT_DW   = pidl_pkg::LENGTH_W + DATA_WIDTH;
    localparam int unsigned OUT_TW   = ((OUT_DW + 7) / 8) * 8;

    // ---- request fields ----
    pidl_pkg::t_mode                 w_mode;
    logic [pidl_pkg::POSITION_W-1:0] w_pos;
    logic [DATA_WIDTH-1:0]           w_value;

    assign w_mode  = pidl_pkg::t_mode'(i_s_tuser);
    assign w_pos   = i_s_tdata[pidl_pkg::POSITION_W-1:0];
    assign w_value = i_s_tdata[pidl_pkg::POSITION_W +: DATA_WIDTH];

    // ---- control state ----
    pidl_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;

    // ---- result payload ----
    pidl_pkg::t_status             r_status, n_status;
    logic [DATA_WIDTH-1:0]         r_rd, n_rd;
    logic [pidl_pkg::LENGTH_W-1:0] r_len, n_len;

    // ---- cell chain ----
    pidl_pkg::t_cell_ctl w_ctl;
    logic [IDX_W-1:0]    w_idx;
    logic [DATA_WIDTH-1:0] w_data    [CAPACITY];
    logic [NGROUP*GRP-1:0][DATA_WIDTH-1:0] w_rd_words;
    logic [DATA_WIDTH-1:0] w_group   [NGROUP];
    logic [DATA_WIDTH-1:0] w_tree_or;

    logic w_accept;
    logic w_full;
    logic w_pos_zero;
    logic [CMP_W-1:0] w_pos_c;
    logic [CMP_W-1:0] w_cnt_c;
    logic [IDX_W-1:0] w_pos_idx;

    assign o_s_tready = (r_state == pidl_pkg::S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_pos_zero = (w_pos == '0);
    assign w_pos_c    = CMP_W'(w_pos);
    assign w_cnt_c    = CMP_W'(r_count);
    assign w_pos_idx  = IDX_W'(w_pos - 1'b1);  // meaningful only when in range

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            if (gi == 0) begin : g_first
                assign w_left = w_value;  // cell 0 never loads from the left
            end else begin : g_mid_l
                assign w_left = w_data[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_right = w_data[gi];  // beyond the list, contents free
            end else begin : g_mid_r
                assign w_right = w_data[gi+1];
            end
            pidl_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IDX_W      (IDX_W),
                .IDX        (gi)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_idx     (w_idx),
                .i_value   (w_value),
                .i_left    (w_left),
                .i_right   (w_right),
                .o_data    (w_data[gi]),
                .o_rd_word (w_rd_words[gi])
            );
        end
        // pad the last partial group with zero words
        for (gi = CAPACITY; gi < NGROUP * GRP; gi++) begin : g_pad
            assign w_rd_words[gi] = '0;
        end
        for (gi = 0; gi < NGROUP; gi++) begin : g_grp
            pidl_group #(
                .DATA_WIDTH (DATA_WIDTH),
                .N          (GRP)
            ) u_group (
                .i_clk   (i_clk),
                .i_words (w_rd_words[gi*GRP +: GRP]),
                .o_word  (w_group[gi])
            );
        end
    endgenerate

    // final level of the read tree
    always_comb begin
        w_tree_or = '0;
        for (int g = 0; g < NGROUP; g++) begin
            w_tree_or = w_tree_or | w_group[g];
        end
    end

    // ---- controller ----
    always_comb begin
        logic              load;
        pidl_pkg::t_status st;

        load        = 1'b0;
        st          = pidl_pkg::ST_OK;
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_tready;
        n_status    = r_status;
        n_rd        = r_rd;
        n_len       = r_len;
        w_ctl.op    = pidl_pkg::CELL_HOLD;
        w_ctl.rd_en = 1'b0;
        w_idx       = w_pos_idx;

        case (r_state)
            pidl_pkg::S_IDLE: begin
                if (w_accept) begin
                    load = 1'b1;
                    case (w_mode)
                        pidl_pkg::MODE_CLEAR: begin
                            n_count = '0;
                        end
                        pidl_pkg::MODE_APPEND: begin
                            if (w_full) begin
                                st = pidl_pkg::ST_FULL;
                            end else begin
                                // append is an insert at the tail
                                w_ctl.op = pidl_pkg::CELL_INSERT;
                                w_idx    = IDX_W'(r_count);
                                n_count  = r_count + 1'b1;
                            end
                        end
                        pidl_pkg::MODE_INSERT: begin
                            if (w_full) begin
                                st = pidl_pkg::ST_FULL;
                            end else if (w_pos_zero || (w_pos_c > w_cnt_c + 1'b1)) begin
                                st = pidl_pkg::ST_RANGE;
                            end else begin
                                w_ctl.op = pidl_pkg::CELL_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        pidl_pkg::MODE_DELETE: begin
                            if (w_pos_zero || (w_pos_c > w_cnt_c)) begin
                                st = pidl_pkg::ST_RANGE;
                            end else begin
                                w_ctl.op = pidl_pkg::CELL_DELETE;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        pidl_pkg::MODE_READ: begin
                            if (w_pos_zero || (w_pos_c > w_cnt_c)) begin
                                st = pidl_pkg::ST_RANGE;
                            end else begin
                                // result comes out of the read tree later
                                load        = 1'b0;
                                w_ctl.rd_en = 1'b1;
                                n_state     = pidl_pkg::S_RD_GROUP;
                            end
                        end
                        default: begin
                            st = pidl_pkg::ST_OK;  // unused codes: no change
                        end
                    endcase
                end
                if (load) begin
                    n_out_valid = 1'b1;
                    n_status    = st;
                    n_rd        = '0;
                    n_len       = pidl_pkg::LENGTH_W'(n_count);
                end
            end
            pidl_pkg::S_RD_GROUP: begin
                n_state = pidl_pkg::S_RD_OUT;
            end
            pidl_pkg::S_RD_OUT: begin
                // result register was emptied when the read was taken
                n_out_valid = 1'b1;
                n_status    = pidl_pkg::ST_OK;
                n_rd        = w_tree_or;
                n_len       = pidl_pkg::LENGTH_W'(r_count);
                n_state     = pidl_pkg::S_IDLE;
            end
            default: begin
                n_state = pidl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pidl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rd     <= n_rd;
        r_len    <= n_len;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_TW'({r_len, r_rd});

endmodule
